// File: src/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants for the radio power sequencer: mode, lock phase
// and IR button codes, register map and fixed timer thresholds.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Operating modes
  typedef enum logic [2:0] {
    MODE_OFF  = 3'd0,
    MODE_BOOT = 3'd1,
    MODE_ON   = 3'd2,
    MODE_WAIT = 3'd3,
    MODE_SHUT = 3'd4
  } mode_e;

  // Lock sub-phase while waiting for shutdown
  typedef enum logic [1:0] {
    PH_CONTACT_OFF   = 2'd0,
    PH_LOCK_INACTIVE = 2'd1,
    PH_LOCK_ACTIVE   = 2'd2
  } phase_e;

  // IR button requests
  typedef enum logic [2:0] {
    IR_NONE     = 3'd0,
    IR_POWER    = 3'd1,
    IR_VOL_UP   = 3'd2,
    IR_VOL_DOWN = 3'd3,
    IR_REPEAT   = 3'd4
  } ir_e;

  // Register indexes (word address paddr[3:2])
  typedef enum logic [1:0] {
    REG_BLINK_WINDOW = 2'd0,
    REG_BOOT_TIMEOUT = 2'd1,
    REG_WAIT_TIMEOUT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_e;

  // Register reset values
  localparam logic [7:0]  BLINK_WINDOW_RST = 8'd15;
  localparam logic [15:0] BOOT_TIMEOUT_RST = 16'd2160;
  localparam logic [15:0] WAIT_TIMEOUT_RST = 16'd1440;

  // Turn-signal age counter
  localparam int unsigned AGE_BITS = 16;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Boot timing thresholds
  localparam int unsigned BOOT_POWER_T   = 39;
  localparam int unsigned BOOT_EARLY_T   = 200;
  localparam int unsigned BOOT_VOL_END_T = 237;
  localparam int unsigned BOOT_HOLD_T    = 238;
  localparam int unsigned BOOT_PRESET_T  = 51;

  // Shutdown timing thresholds
  localparam int unsigned SHUT_WAKE_ON_T = 80;
  localparam int unsigned SHUT_POWER_T   = 82;
  localparam int unsigned SHUT_REPEAT_T  = 83;
  localparam int unsigned SHUT_HOLD_T    = 110;
  localparam int unsigned SHUT_END_T     = 130;

endpackage

// File: src/radio_power_sequencer.sv
// ----------------------------------------------------------------------------
// radio_power_sequencer
// Power sequencing for a car radio: a five-mode machine driven one tick per
// input word, reporting LED/relay levels, the mode and an IR button request.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  tick in  | in_valid_i / in_ready_o    | accessory_on_i lock_on_i blinker_on_i
//  result   | out_valid_o / out_ready_i  | led_red_o led_grn_o
//           |                            | accessory_relay_o ir_command_o mode_now_o
//  config   | psel penable pwrite pready | paddr pwdata prdata
//
//  One tick word per cycle while the result slot is empty or being drained:
//  the whole step is computed from the state registers in the accepting
//  cycle, and the result word is valid the cycle after the tick is accepted.
//  The result register is the only stage, so a stalled result holds the input
//  only when it is full and not being taken.
//  Reset (rst_ni low, asynchronous) puts the machine in off mode, clears the
//  mode timer, sets the blink age to its maximum and loads register defaults.
// ----------------------------------------------------------------------------
module radio_power_sequencer
  import rps_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        accessory_on_i,
  input  logic        lock_on_i,
  input  logic        blinker_on_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        led_red_o,
  output logic        led_grn_o,
  output logic        accessory_relay_o,
  output logic [2:0]  ir_command_o,
  output logic [2:0]  mode_now_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TimerMax = '1;

  // Registers
  logic [7:0]            blink_window_q;
  logic [15:0]           boot_timeout_q;
  logic [15:0]           wait_timeout_q;
  mode_e                 mode_q, mode_d;
  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic [AGE_BITS-1:0]   age_q, age_d;
  logic                  out_valid_q;
  logic                  led_red_q, led_grn_q, relay_q;
  ir_e                   ir_q;
  mode_e                 mode_now_q;

  // Combinational step signals
  logic                  in_fire;
  logic                  cfg_wr;
  reg_e                  cfg_idx;
  logic                  recent;
  logic [CmpW-1:0]       t_wide;
  logic [TIMER_BITS-1:0] t;
  logic [TIMER_BITS-1:0] ticks_set;
  logic                  red, green, relay;
  ir_e                   ir;
  logic                  wake;

  // Handshake: take a tick when the result slot is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_window_q <= BLINK_WINDOW_RST;
      boot_timeout_q <= BOOT_TIMEOUT_RST;
      wait_timeout_q <= WAIT_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BLINK_WINDOW: blink_window_q <= pwdata[7:0];
        REG_BOOT_TIMEOUT: boot_timeout_q <= pwdata[15:0];
        REG_WAIT_TIMEOUT: wait_timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_BLINK_WINDOW: prdata = {24'd0, blink_window_q};
      REG_BOOT_TIMEOUT: prdata = {16'd0, boot_timeout_q};
      REG_WAIT_TIMEOUT: prdata = {16'd0, wait_timeout_q};
      default:          prdata = 32'd0;
    endcase
  end

  // Step the mode machine for one tick
  assign t      = ticks_q;
  assign t_wide = CmpW'(ticks_q);
  assign recent = age_q < AGE_BITS'(blink_window_q);
  assign wake   = accessory_on_i || (!lock_on_i && recent);

  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    ticks_set = ticks_q;
    ir        = IR_NONE;
    red       = 1'b1;
    green     = 1'b1;
    relay     = 1'b0;
    unique case (mode_q)
      MODE_BOOT: begin
        red   = 1'b1;
        green = 1'b0;
        relay = 1'b1;
        if (lock_on_i && recent) begin
          if (t < TIMER_BITS'(BOOT_POWER_T)) begin
            mode_d    = MODE_OFF;
            ticks_set = '0;
          end else if (t < TIMER_BITS'(BOOT_EARLY_T)) begin
            mode_d    = MODE_SHUT;
            ticks_set = TIMER_BITS'(BOOT_PRESET_T);
          end else begin
            mode_d    = MODE_SHUT;
            ticks_set = '0;
          end
        end else if (t == TIMER_BITS'(BOOT_POWER_T)) begin
          ir = IR_POWER;
        end else if (t > TIMER_BITS'(BOOT_EARLY_T)) begin
          if (t <= TIMER_BITS'(BOOT_VOL_END_T)) begin
            if (t[0]) begin
              ir = IR_VOL_UP;
            end
          end else if (blinker_on_i) begin
            // postpone the timeout while the turn signal is lit
            ticks_set = TIMER_BITS'(BOOT_HOLD_T);
          end else if (accessory_on_i) begin
            mode_d    = MODE_ON;
            ticks_set = '0;
          end else if (t_wide > CmpW'(boot_timeout_q)) begin
            mode_d    = MODE_SHUT;
            ticks_set = '0;
          end
        end
      end
      MODE_ON: begin
        red   = 1'b0;
        green = 1'b0;
        relay = 1'b1;
        if (!accessory_on_i) begin
          phase_d   = PH_CONTACT_OFF;
          mode_d    = MODE_WAIT;
          ticks_set = '0;
        end
      end
      MODE_WAIT: begin
        red   = 1'b0;
        green = 1'b1;
        relay = 1'b1;
        // advance the lock sub-phase before deciding on shutdown
        if (phase_q == PH_CONTACT_OFF) begin
          if (!lock_on_i) begin
            phase_d = PH_LOCK_INACTIVE;
          end
        end else if (phase_q == PH_LOCK_INACTIVE) begin
          if (lock_on_i && recent) begin
            phase_d = PH_LOCK_ACTIVE;
          end
        end
        if (accessory_on_i) begin
          mode_d    = MODE_ON;
          ticks_set = '0;
        end else if (t_wide > CmpW'(wait_timeout_q) || phase_d == PH_LOCK_ACTIVE) begin
          mode_d    = MODE_SHUT;
          ticks_set = '0;
        end
      end
      MODE_SHUT: begin
        red   = 1'b0;
        green = 1'b1;
        relay = 1'b1;
        if (wake) begin
          if (t <= TIMER_BITS'(SHUT_WAKE_ON_T)) begin
            mode_d    = MODE_ON;
            ticks_set = '0;
          end else if (t <= TIMER_BITS'(SHUT_HOLD_T)) begin
            // hold: radio is mid power-off
          end else if (t <= TIMER_BITS'(SHUT_END_T)) begin
            mode_d    = MODE_BOOT;
            ticks_set = '0;
          end
        end else if (t > TIMER_BITS'(SHUT_END_T)) begin
          mode_d    = MODE_OFF;
          ticks_set = '0;
        end else if (t >= TIMER_BITS'(SHUT_HOLD_T)) begin
          // hold: nothing to send
        end else if (t >= TIMER_BITS'(SHUT_REPEAT_T)) begin
          ir = IR_REPEAT;
        end else if (t == TIMER_BITS'(SHUT_POWER_T)) begin
          ir = IR_POWER;
        end else if (t < TIMER_BITS'(SHUT_WAKE_ON_T) && t[0]) begin
          ir = IR_VOL_DOWN;
        end
      end
      default: begin
        // off, and any unused mode code
        red   = 1'b1;
        green = 1'b1;
        relay = 1'b0;
        if (accessory_on_i || (recent && !lock_on_i)) begin
          mode_d    = MODE_BOOT;
          ticks_set = '0;
        end
      end
    endcase

    // Advance the saturating counters
    ticks_d = (ticks_set == TimerMax) ? ticks_set : ticks_set + 1'b1;
    if (blinker_on_i) begin
      age_d = '0;
    end else if (age_q != AGE_MAX) begin
      age_d = age_q + 1'b1;
    end else begin
      age_d = age_q;
    end
  end

  // State registers, updated once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      phase_q <= PH_CONTACT_OFF;
      ticks_q <= '0;
      age_q   <= AGE_MAX;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      age_q   <= age_d;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      led_red_q   <= red;
      led_grn_q   <= green;
      relay_q     <= relay;
      ir_q        <= ir;
      mode_now_q  <= mode_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign led_red_o         = led_red_q;
  assign led_grn_o         = led_grn_q;
  assign accessory_relay_o = relay_q;
  assign ir_command_o      = ir_q;
  assign mode_now_o        = mode_now_q;

  // Assertions

  // hold all sequencing state when no tick is taken
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(mode_q) && $stable(ticks_q) && $stable(age_q)
                 && $stable(phase_q))
    else $error("sequencer state moved without an accepted tick");

  // a mode change restarts the timer, from zero or from the boot preset
  a_mode_timer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (mode_d != mode_q) |=>
      (ticks_q == TIMER_BITS'(1)) || (ticks_q == TIMER_BITS'(BOOT_PRESET_T + 1)))
    else $error("timer not restarted on mode change");

  // the relay is released only in off mode
  a_relay_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accessory_relay_o |-> mode_now_o == MODE_OFF)
    else $error("relay released outside off mode");

  // IR requests come only from boot or shutdown
  a_ir_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ir_command_o != IR_NONE |->
      mode_now_o == MODE_BOOT || mode_now_o == MODE_SHUT)
    else $error("IR request in a mode that sends none");

  // a lit turn signal clears the blink age
  a_blink_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && blinker_on_i |=> age_q == '0)
    else $error("blink age not cleared");

endmodule
